FILE: rtl/stkvm_pkg.sv
// stkvm_pkg: shared constants, opcode and state types for the stack machine executor
// no dependencies
package stkvm_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int VAR_COUNT_DEF   = 256;
    localparam int CALL_DEPTH_DEF  = 64;
    localparam int ADDR_WIDTH_DEF  = 16;

    localparam int DATA_W      = 32;
    localparam int OPC_W       = 5;
    localparam int PLEN_W      = 16;
    localparam int NADDR_W     = 16;
    localparam int DEPTH_OUT_W = 11;

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH_IMM  = 5'd0,
        OP_PUSH_VAR  = 5'd1,
        OP_POP_VAR   = 5'd2,
        OP_ADD       = 5'd3,
        OP_SUB       = 5'd4,
        OP_MUL       = 5'd5,
        OP_DIV       = 5'd6,
        OP_NEG       = 5'd7,
        OP_NOT       = 5'd8,
        OP_EQ        = 5'd9,
        OP_NE        = 5'd10,
        OP_LT        = 5'd11,
        OP_LE        = 5'd12,
        OP_GT        = 5'd13,
        OP_GE        = 5'd14,
        OP_AND       = 5'd15,
        OP_OR        = 5'd16,
        OP_JMP       = 5'd17,
        OP_JMP_FALSE = 5'd18,
        OP_LABEL     = 5'd19,
        OP_CALL      = 5'd20,
        OP_RET       = 5'd21,
        OP_HALT      = 5'd22,
        OP_DUP       = 5'd23,
        OP_SWAP      = 5'd24,
        OP_PRINT     = 5'd25
    } opcode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_SWAP,
        ST_OUT
    } state_t;

endpackage

FILE: rtl/stkvm_ram.sv
// stkvm_ram: generic single write port ram with one registered read port
// no dependencies
module stkvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/stkvm_div.sv
// stkvm_div: iterative signed 32-bit divider, one quotient bit per cycle
// depends on stkvm_pkg
module stkvm_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [stkvm_pkg::DATA_W-1:0]     dividend,
    input  logic [stkvm_pkg::DATA_W-1:0]     divisor,
    output logic                             done,
    output logic [stkvm_pkg::DATA_W-1:0]     quotient
);

    localparam int W  = stkvm_pkg::DATA_W;
    localparam int CW = $clog2(W);

    logic          run_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg;
    logic          zero_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  den_reg;
    logic [W:0]    shifted;
    logic [W:0]    trial;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[W-1] ^ divisor[W-1];
            zero_reg <= (divisor == '0);
            quo_reg  <= dividend[W-1] ? (W'(0) - dividend) : dividend;
            den_reg  <= divisor[W-1] ? (W'(0) - divisor) : divisor;
            rem_reg  <= '0;
        end
        else if (run_reg)
        begin
            if (!trial[W])
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : (neg_reg ? (W'(0) - quo_reg) : quo_reg);

endmodule

FILE: rtl/stack_vm_instruction_executor.sv
// stack_vm_instruction_executor: top level of the stack machine executor
// depends on stkvm_pkg, stkvm_ram, stkvm_div
//
// usage
// the host writes program_length through the cfg channel (cfg_valid/cfg_ready,
// cfg_data); cfg_ready is always high and a write takes effect at once.
// the host then feeds the instruction found at next_address on the input
// channel (in_valid, in_stall driven here); one result word per instruction
// comes out on the output channel (out_valid, out_stall driven by the receiver).
// one instruction at a time: accept, an execute state with the memory read
// data, then the result word in the out state. swap adds a state for its second
// stack write; div waits in its own state while the divider makes one quotient
// bit a cycle. a new instruction is taken only once the last result word has gone out.
// data stack, variable store and return stack live in rams with one write port
// and a registered read port; the top of stack is also kept in a register.
// after reset the variable store is cleared, one entry a cycle over all VAR_COUNT
// entries, with in_stall high; cfg writes are taken during that time.
// while out_stall is high the result word holds and no input is taken.
module stack_vm_instruction_executor #(
    parameter int STACK_DEPTH = stkvm_pkg::STACK_DEPTH_DEF,
    parameter int VAR_COUNT   = stkvm_pkg::VAR_COUNT_DEF,
    parameter int CALL_DEPTH  = stkvm_pkg::CALL_DEPTH_DEF,
    parameter int ADDR_WIDTH  = stkvm_pkg::ADDR_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [stkvm_pkg::OPC_W-1:0]           opcode,
    input  logic signed [stkvm_pkg::DATA_W-1:0]   operand,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [stkvm_pkg::NADDR_W-1:0]         next_address,
    output logic                                  halted,
    output logic                                  print_valid,
    output logic signed [stkvm_pkg::DATA_W-1:0]   print_value,
    output logic signed [stkvm_pkg::DATA_W-1:0]   top_value,
    output logic [stkvm_pkg::DEPTH_OUT_W-1:0]     stack_depth,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [stkvm_pkg::PLEN_W-1:0]          cfg_data
);

    localparam int W    = stkvm_pkg::DATA_W;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int DA_W = $clog2(STACK_DEPTH);
    localparam int VA_W = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam int RP_W = $clog2(CALL_DEPTH + 1);
    localparam int RA_W = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
    localparam int AW   = ADDR_WIDTH;

    stkvm_pkg::state_t state_reg, state_next;

    logic [SP_W-1:0]                 sp_reg, sp_next;
    logic [RP_W-1:0]                 rp_reg, rp_next;
    logic [AW-1:0]                   ip_reg, ip_next;
    logic [W-1:0]                    tos_reg, tos_next;
    logic [stkvm_pkg::PLEN_W-1:0]    plen_reg;
    logic [VA_W-1:0]                 clr_reg;
    logic [stkvm_pkg::OPC_W-1:0]     op_reg;
    logic [W-1:0]                    opnd_reg;
    logic                            pv_reg, pv_next;
    logic [W-1:0]                    pval_reg, pval_next;
    logic [W-1:0]                    swap_reg;

    logic            ds_we;
    logic [DA_W-1:0] ds_waddr;
    logic [W-1:0]    ds_wdata;
    logic [W-1:0]    ds_rdata;
    logic            vs_we;
    logic [VA_W-1:0] vs_waddr;
    logic [W-1:0]    vs_wdata;
    logic [VA_W-1:0] vs_raddr;
    logic [W-1:0]    vs_rdata;
    logic            rs_we;
    logic [AW-1:0]   rs_rdata;

    logic            div_start;
    logic            div_done;
    logic [W-1:0]    div_q;

    logic            run_ok;
    logic            target_ok;
    logic            var_ok;
    logic            sp_ge1, sp_ge2, sp_full;
    logic [W-1:0]    x_top, x_sec;
    logic [SP_W-1:0] bin_sp, una_sp;
    logic [W-1:0]    bin_res, una_res;
    logic [AW-1:0]   ip_inc;
    logic [AW-1:0]   plen_ip;

    // ---------------- memories ----------------
    stkvm_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH), .AW(DA_W)) u_data_ram (
        .clk   (clk),
        .we    (ds_we),
        .waddr (ds_waddr),
        .wdata (ds_wdata),
        .raddr (DA_W'(sp_reg - SP_W'(2))),
        .rdata (ds_rdata)
    );

    stkvm_ram #(.WIDTH(W), .DEPTH(VAR_COUNT), .AW(VA_W)) u_var_ram (
        .clk   (clk),
        .we    (vs_we),
        .waddr (vs_waddr),
        .wdata (vs_wdata),
        .raddr (vs_raddr),
        .rdata (vs_rdata)
    );

    stkvm_ram #(.WIDTH(AW), .DEPTH(CALL_DEPTH), .AW(RA_W)) u_ret_ram (
        .clk   (clk),
        .we    (rs_we),
        .waddr (RA_W'(rp_reg)),
        .wdata (ip_inc),
        .raddr (RA_W'(rp_reg - RP_W'(1))),
        .rdata (rs_rdata)
    );

    stkvm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (x_sec),
        .divisor  (x_top),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------- operand decode ----------------
    assign vs_raddr  = VA_W'(operand);
    assign run_ok    = (32'(ip_reg) < 32'(plen_reg));
    assign target_ok = !opnd_reg[W-1] && (opnd_reg < 32'(plen_reg));
    assign var_ok    = !opnd_reg[W-1] && (opnd_reg < 32'(VAR_COUNT));
    assign sp_ge1    = (sp_reg != '0);
    assign sp_ge2    = (sp_reg >= SP_W'(2));
    assign sp_full   = (sp_reg >= SP_W'(STACK_DEPTH));
    assign x_top     = sp_ge1 ? tos_reg : '0;
    assign x_sec     = sp_ge2 ? ds_rdata : '0;
    assign bin_sp    = sp_ge2 ? (sp_reg - SP_W'(1)) : SP_W'(1);
    assign una_sp    = sp_ge1 ? sp_reg : SP_W'(1);
    assign ip_inc    = ip_reg + AW'(1);
    assign plen_ip   = AW'(32'(plen_reg));

    always_comb
    begin
        case (stkvm_pkg::opcode_t'(op_reg))
            stkvm_pkg::OP_ADD: bin_res = x_sec + x_top;
            stkvm_pkg::OP_SUB: bin_res = x_sec - x_top;
            stkvm_pkg::OP_MUL: bin_res = x_sec * x_top;
            stkvm_pkg::OP_EQ:  bin_res = W'(x_sec == x_top);
            stkvm_pkg::OP_NE:  bin_res = W'(x_sec != x_top);
            stkvm_pkg::OP_LT:  bin_res = W'($signed(x_sec) < $signed(x_top));
            stkvm_pkg::OP_LE:  bin_res = W'($signed(x_sec) <= $signed(x_top));
            stkvm_pkg::OP_GT:  bin_res = W'($signed(x_sec) > $signed(x_top));
            stkvm_pkg::OP_GE:  bin_res = W'($signed(x_sec) >= $signed(x_top));
            stkvm_pkg::OP_AND: bin_res = W'((x_sec != '0) && (x_top != '0));
            stkvm_pkg::OP_OR:  bin_res = W'((x_sec != '0) || (x_top != '0));
            default:           bin_res = '0;
        endcase
        una_res = (op_reg == stkvm_pkg::OP_NEG) ? (W'(0) - x_top) : W'(x_top == '0);
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stkvm_pkg::ST_CLEAR:
            begin
                if (clr_reg == VA_W'(VAR_COUNT - 1))
                begin
                    state_next = stkvm_pkg::ST_IDLE;
                end
            end
            stkvm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stkvm_pkg::ST_EXEC;
                end
            end
            stkvm_pkg::ST_EXEC:
            begin
                if (run_ok && op_reg == stkvm_pkg::OP_DIV)
                begin
                    state_next = stkvm_pkg::ST_DIV;
                end
                else if (run_ok && op_reg == stkvm_pkg::OP_SWAP && sp_ge2)
                begin
                    state_next = stkvm_pkg::ST_SWAP;
                end
                else
                begin
                    state_next = stkvm_pkg::ST_OUT;
                end
            end
            stkvm_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = stkvm_pkg::ST_OUT;
                end
            end
            stkvm_pkg::ST_SWAP:
            begin
                state_next = stkvm_pkg::ST_OUT;
            end
            stkvm_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = stkvm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stkvm_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- outputs and datapath control ----------------
    always_comb
    begin
        sp_next   = sp_reg;
        rp_next   = rp_reg;
        ip_next   = ip_reg;
        tos_next  = tos_reg;
        pv_next   = pv_reg;
        pval_next = pval_reg;
        ds_we     = 1'b0;
        ds_waddr  = DA_W'(sp_reg);
        ds_wdata  = '0;
        vs_we     = 1'b0;
        vs_waddr  = VA_W'(opnd_reg);
        vs_wdata  = x_top;
        rs_we     = 1'b0;
        div_start = 1'b0;
        in_stall  = (state_reg != stkvm_pkg::ST_IDLE);
        out_valid = (state_reg == stkvm_pkg::ST_OUT);
        case (state_reg)
            stkvm_pkg::ST_CLEAR:
            begin
                vs_we    = 1'b1;
                vs_waddr = clr_reg;
                vs_wdata = '0;
            end
            stkvm_pkg::ST_EXEC:
            begin
                pv_next   = 1'b0;
                pval_next = '0;
                if (run_ok)
                begin
                    ip_next = ip_inc;
                    case (stkvm_pkg::opcode_t'(op_reg))
                        stkvm_pkg::OP_PUSH_IMM, stkvm_pkg::OP_PUSH_VAR, stkvm_pkg::OP_DUP:
                        begin
                            if (op_reg == stkvm_pkg::OP_PUSH_IMM)
                            begin
                                ds_wdata = opnd_reg;
                            end
                            else if (op_reg == stkvm_pkg::OP_PUSH_VAR)
                            begin
                                ds_wdata = var_ok ? vs_rdata : '0;
                            end
                            else
                            begin
                                ds_wdata = tos_reg;
                            end
                            if (!sp_full && (op_reg != stkvm_pkg::OP_DUP || sp_ge1))
                            begin
                                ds_we    = 1'b1;
                                sp_next  = sp_reg + SP_W'(1);
                                tos_next = ds_wdata;
                            end
                        end
                        stkvm_pkg::OP_POP_VAR, stkvm_pkg::OP_JMP_FALSE, stkvm_pkg::OP_PRINT:
                        begin
                            if (op_reg != stkvm_pkg::OP_POP_VAR || var_ok)
                            begin
                                sp_next  = sp_ge1 ? (sp_reg - SP_W'(1)) : sp_reg;
                                tos_next = ds_rdata;
                            end
                            if (op_reg == stkvm_pkg::OP_POP_VAR)
                            begin
                                vs_we = var_ok;
                            end
                            if (op_reg == stkvm_pkg::OP_JMP_FALSE && x_top == '0 && target_ok)
                            begin
                                ip_next = AW'(opnd_reg);
                            end
                            if (op_reg == stkvm_pkg::OP_PRINT)
                            begin
                                pv_next   = 1'b1;
                                pval_next = x_top;
                            end
                        end
                        stkvm_pkg::OP_NEG, stkvm_pkg::OP_NOT:
                        begin
                            ds_we    = 1'b1;
                            ds_waddr = DA_W'(una_sp - SP_W'(1));
                            ds_wdata = una_res;
                            sp_next  = una_sp;
                            tos_next = una_res;
                        end
                        stkvm_pkg::OP_ADD, stkvm_pkg::OP_SUB, stkvm_pkg::OP_MUL,
                        stkvm_pkg::OP_EQ, stkvm_pkg::OP_NE, stkvm_pkg::OP_LT,
                        stkvm_pkg::OP_LE, stkvm_pkg::OP_GT, stkvm_pkg::OP_GE,
                        stkvm_pkg::OP_AND, stkvm_pkg::OP_OR:
                        begin
                            ds_we    = 1'b1;
                            ds_waddr = DA_W'(bin_sp - SP_W'(1));
                            ds_wdata = bin_res;
                            sp_next  = bin_sp;
                            tos_next = bin_res;
                        end
                        stkvm_pkg::OP_DIV:
                        begin
                            div_start = 1'b1;
                            ip_next   = ip_reg;
                        end
                        stkvm_pkg::OP_JMP:
                        begin
                            if (target_ok)
                            begin
                                ip_next = AW'(opnd_reg);
                            end
                        end
                        stkvm_pkg::OP_CALL:
                        begin
                            if (rp_reg < RP_W'(CALL_DEPTH))
                            begin
                                rs_we   = 1'b1;
                                rp_next = rp_reg + RP_W'(1);
                            end
                            ip_next = '0;
                        end
                        stkvm_pkg::OP_RET:
                        begin
                            if (rp_reg != '0)
                            begin
                                ip_next = rs_rdata;
                                rp_next = rp_reg - RP_W'(1);
                            end
                            else
                            begin
                                ip_next = plen_ip;
                            end
                        end
                        stkvm_pkg::OP_HALT:
                        begin
                            ip_next = plen_ip;
                        end
                        stkvm_pkg::OP_SWAP:
                        begin
                            if (sp_ge2)
                            begin
                                ds_we    = 1'b1;
                                ds_waddr = DA_W'(sp_reg - SP_W'(1));
                                ds_wdata = ds_rdata;
                                tos_next = ds_rdata;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            stkvm_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    ds_we    = 1'b1;
                    ds_waddr = DA_W'(bin_sp - SP_W'(1));
                    ds_wdata = div_q;
                    sp_next  = bin_sp;
                    tos_next = div_q;
                    ip_next  = ip_inc;
                end
            end
            stkvm_pkg::ST_SWAP:
            begin
                ds_we    = 1'b1;
                ds_waddr = DA_W'(sp_reg - SP_W'(2));
                ds_wdata = swap_reg;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stkvm_pkg::ST_CLEAR;
            sp_reg    <= '0;
            rp_reg    <= '0;
            ip_reg    <= '0;
            plen_reg  <= '0;
            clr_reg   <= '0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            rp_reg    <= rp_next;
            ip_reg    <= ip_next;
            pv_reg    <= pv_next;
            if (state_reg == stkvm_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + VA_W'(1);
            end
            if (cfg_valid)
            begin
                plen_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg  <= tos_next;
        pval_reg <= pval_next;
        if (state_reg == stkvm_pkg::ST_IDLE)
        begin
            op_reg   <= opcode;
            opnd_reg <= operand;
        end
        if (state_reg == stkvm_pkg::ST_EXEC)
        begin
            swap_reg <= tos_reg;
        end
    end

    assign cfg_ready    = 1'b1;
    assign next_address = stkvm_pkg::NADDR_W'(32'(ip_reg));
    assign halted       = !run_ok;
    assign print_valid  = pv_reg;
    assign print_value  = pval_reg;
    assign top_value    = sp_ge1 ? tos_reg : '0;
    assign stack_depth  = stkvm_pkg::DEPTH_OUT_W'(sp_reg);

endmodule
